@@ hdl/hscm_pkg.sv @@
// shared constants, register codes and the pipeline item type of the site coordinate mapper
`default_nettype none
package hscm_pkg;

    localparam int MAX_DIMS     = 4;
    localparam int COORD_BITS   = 12;
    localparam int INDEX_BITS   = 24;
    localparam int LOC_BITS     = COORD_BITS + 1;
    localparam int REG_BITS     = 48;
    localparam int DIMS_BITS    = 3;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_DIMS     = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SLICE    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNTS   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_LATTICE  = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_POSITION = CFG_IDX_BITS'(4);

    localparam logic [DIMS_BITS-1:0] RST_DIMS     = DIMS_BITS'(MAX_DIMS);
    localparam logic [REG_BITS-1:0]  RST_ALL_ONES = REG_BITS'(48'h0010_0100_1001);

    // payload that rides along the divider chains
    typedef struct packed {
        logic [MAX_DIMS-1:0][LOC_BITS-1:0]   x;
        logic [MAX_DIMS-1:0][COORD_BITS-1:0] g;
        logic                                halo;
        logic                                err;
    } item_t;

endpackage
`default_nettype wire

@@ hdl/hscm_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with a payload riding along
`default_nettype none
module hscm_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire hscm_pkg::item_t                     in_side,
    input  wire logic [hscm_pkg::INDEX_BITS-1:0]     dividend,
    input  wire logic [hscm_pkg::LOC_BITS-1:0]       divisor,
    output logic                                     out_valid,
    output hscm_pkg::item_t                          out_side,
    output logic [hscm_pkg::INDEX_BITS-1:0]          quot,
    output logic [hscm_pkg::LOC_BITS-1:0]            rem
);

    localparam int IW = hscm_pkg::INDEX_BITS;
    localparam int RW = hscm_pkg::LOC_BITS;

    logic                   v_reg    [IW];
    hscm_pkg::item_t        side_reg [IW];
    logic [IW-1:0]          n_reg    [IW];
    logic [RW-1:0]          r_reg    [IW];

    logic                   v_in     [IW];
    hscm_pkg::item_t        side_in  [IW];
    logic [IW-1:0]          n_in     [IW];
    logic [RW-1:0]          r_in     [IW];
    logic [RW:0]            trial    [IW];
    logic [RW:0]            diff     [IW];
    logic                   ge       [IW];

    genvar s;
    generate
        for (s = 0; s < IW; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign v_in[s]    = in_valid;
                assign side_in[s] = in_side;
                assign n_in[s]    = dividend;
                assign r_in[s]    = '0;
            end
            else
            begin : g_next
                assign v_in[s]    = v_reg[s-1];
                assign side_in[s] = side_reg[s-1];
                assign n_in[s]    = n_reg[s-1];
                assign r_in[s]    = r_reg[s-1];
            end

            // shift in the next dividend bit and try the subtract
            assign trial[s] = {r_in[s], n_in[s][IW-1]};
            assign diff[s]  = trial[s] - {1'b0, divisor};
            assign ge[s]    = (trial[s] >= {1'b0, divisor});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s] <= v_in[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[s] <= side_in[s];
                    n_reg[s]    <= {n_in[s][IW-2:0], ge[s]};
                    r_reg[s]    <= ge[s] ? diff[s][RW-1:0] : trial[s][RW-1:0];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[IW-1];
    assign out_side  = side_reg[IW-1];
    assign quot      = n_reg[IW-1];
    assign rem       = r_reg[IW-1];

endmodule
`default_nettype wire

@@ hdl/halo_site_coordinate_mapper_unit.sv @@
// throughput: one transaction per cycle unless stalled; six 24-stage divider chains plus three
//   single stages make up the pipeline, four dividers in series decode the index
// stalls hold the whole pipeline only when its last stage and the output register are both full and out_ready is low
// reset: configuration returns to four dimensions, unit lengths and counts, node at origin;
//   all valid bits clear, no memory to sweep
`default_nettype none
module halo_site_coordinate_mapper_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [hscm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [hscm_pkg::REG_BITS-1:0]         cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [hscm_pkg::INDEX_BITS-1:0]       site_index,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [hscm_pkg::COORD_BITS-1:0]            phys_coord_0,
    output logic [hscm_pkg::COORD_BITS-1:0]            phys_coord_1,
    output logic [hscm_pkg::COORD_BITS-1:0]            phys_coord_2,
    output logic [hscm_pkg::COORD_BITS-1:0]            phys_coord_3,
    output logic                                       is_halo,
    output logic                                       site_parity,
    output logic [hscm_pkg::INDEX_BITS-1:0]            owner_rank,
    output logic                                       index_error
);

    localparam int ND = hscm_pkg::MAX_DIMS;
    localparam int CB = hscm_pkg::COORD_BITS;
    localparam int IB = hscm_pkg::INDEX_BITS;
    localparam int LB = hscm_pkg::LOC_BITS;
    localparam int DB = hscm_pkg::DIMS_BITS;

    // configuration registers
    logic [DB-1:0]                    dims_reg;
    logic [hscm_pkg::REG_BITS-1:0]    slice_reg;
    logic [hscm_pkg::REG_BITS-1:0]    count_reg;
    logic [hscm_pkg::REG_BITS-1:0]    lattice_reg;
    logic [hscm_pkg::REG_BITS-1:0]    position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg     <= hscm_pkg::RST_DIMS;
            slice_reg    <= hscm_pkg::RST_ALL_ONES;
            count_reg    <= hscm_pkg::RST_ALL_ONES;
            lattice_reg  <= hscm_pkg::RST_ALL_ONES;
            position_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hscm_pkg::REG_DIMS:     dims_reg     <= cfg_data[DB-1:0];
                hscm_pkg::REG_SLICE:    slice_reg    <= cfg_data;
                hscm_pkg::REG_COUNTS:   count_reg    <= cfg_data;
                hscm_pkg::REG_LATTICE:  lattice_reg  <= cfg_data;
                hscm_pkg::REG_POSITION: position_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DB-1:0] nd;

    always_comb
    begin
        if (dims_reg == '0)
            nd = DB'(1);
        else if (dims_reg > DB'(ND))
            nd = DB'(ND);
        else
            nd = dims_reg;
    end

    logic [CB-1:0]   sl      [ND];
    logic [CB-1:0]   cnt     [ND];
    logic [CB-1:0]   pos     [ND];
    logic [CB-1:0]   lat     [ND];
    logic            used    [ND];
    logic [LB-1:0]   div_a   [ND];
    logic [2*CB-1:0] base_full [ND];
    logic [CB-1:0]   base_reg  [ND];
    logic [IB-1:0]   radix   [ND];

    genvar k;
    generate
        for (k = 0; k < ND; k++)
        begin : g_cfg
            assign sl[k]    = slice_reg[k*CB +: CB];
            assign cnt[k]   = count_reg[k*CB +: CB];
            assign pos[k]   = position_reg[k*CB +: CB];
            assign lat[k]   = lattice_reg[k*CB +: CB];
            assign used[k]  = (DB'(k) < nd);
            // unused dimensions divide by one so the quotient passes straight on
            assign div_a[k] = used[k] ? ({1'b0, sl[k]} + LB'(2)) : LB'(1);
            assign base_full[k] = pos[k] * sl[k];

            always_ff @(posedge clk)
            begin
                base_reg[k] <= base_full[k][CB-1:0];
            end
        end
    endgenerate

    // place values of the node grid, settled long before any transaction reaches the rank stage
    logic [2*CB-1:0]  rad01_full;
    logic [IB-1:0]    rad01_reg;
    logic [IB+CB-1:0] rad012_full;
    logic [IB-1:0]    rad012_reg;

    assign rad01_full  = cnt[0] * cnt[1];
    assign rad012_full = rad01_reg * cnt[2];

    always_ff @(posedge clk)
    begin
        rad01_reg  <= IB'(rad01_full);
        rad012_reg <= rad012_full[IB-1:0];
    end

    assign radix[0] = IB'(1);
    assign radix[1] = IB'(cnt[0]);
    assign radix[2] = rad01_reg;
    assign radix[3] = rad012_reg;

    // pipeline flow control
    logic out_valid_reg;
    logic out_en;
    logic pipe_en;
    logic m_v_reg;

    assign out_en   = !out_valid_reg || out_ready;
    assign pipe_en  = !m_v_reg || out_en;
    assign in_ready = pipe_en;

    // index decode: one divider chain per dimension in series
    logic              a_v   [ND+1];
    hscm_pkg::item_t   a_s   [ND+1];
    logic [IB-1:0]     a_n   [ND+1];
    hscm_pkg::item_t   a_raw [ND];
    logic [LB-1:0]     a_r   [ND];

    assign a_v[0] = in_valid;
    assign a_s[0] = '0;
    assign a_n[0] = site_index;

    generate
        for (k = 0; k < ND; k++)
        begin : g_decode
            hscm_div u_div_a (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (pipe_en),
                .in_valid  (a_v[k]),
                .in_side   (a_s[k]),
                .dividend  (a_n[k]),
                .divisor   (div_a[k]),
                .out_valid (a_v[k+1]),
                .out_side  (a_raw[k]),
                .quot      (a_n[k+1]),
                .rem       (a_r[k])
            );

            always_comb
            begin
                a_s[k+1]      = a_raw[k];
                a_s[k+1].x[k] = a_r[k];
            end
        end
    endgenerate

    // global coordinate stage
    hscm_pkg::item_t g_next;
    hscm_pkg::item_t g_item_reg;
    logic            g_v_reg;

    always_comb
    begin
        logic [LB-1:0] x;
        logic [LB-1:0] plain;
        logic          top_edge;
        logic          wrap_hi;
        g_next      = a_s[ND];
        g_next.halo = 1'b0;
        g_next.err  = (a_n[ND] != '0);
        for (int d = 0; d < ND; d++)
        begin
            x        = a_s[ND].x[d];
            plain    = x + LB'(base_reg[d]) - LB'(1);
            top_edge = (x == ({1'b0, sl[d]} + LB'(1)));
            wrap_hi  = (({1'b0, pos[d]} + LB'(1)) >= {1'b0, cnt[d]});
            if (!used[d])
            begin
                g_next.g[d] = '0;
            end
            else if (top_edge)
            begin
                g_next.halo = 1'b1;
                g_next.g[d] = wrap_hi ? '0 : (base_reg[d] + sl[d]);
            end
            else if (x == '0)
            begin
                g_next.halo = 1'b1;
                g_next.g[d] = (pos[d] == '0) ? (lat[d] - CB'(1)) : (base_reg[d] - CB'(1));
            end
            else
            begin
                g_next.g[d] = plain[CB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_v_reg <= 1'b0;
        else if (pipe_en)
            g_v_reg <= a_v[ND];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            g_item_reg <= g_next;
    end

    // node coordinate (g / slice) then its residue modulo the node count, four lanes
    logic              b_v;
    hscm_pkg::item_t   b_s;
    logic [IB-1:0]     b_q  [ND];
    logic [IB-1:0]     nc   [ND];
    logic              c_v;
    hscm_pkg::item_t   c_s;
    logic [LB-1:0]     c_r  [ND];

    generate
        for (k = 0; k < ND; k++)
        begin : g_rank_div
            assign nc[k] = (sl[k] == '0) ? '0 : IB'(b_q[k][CB-1:0]);

            if (k == 0)
            begin : g_lead
                hscm_div u_div_b (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (pipe_en),
                    .in_valid  (g_v_reg),
                    .in_side   (g_item_reg),
                    .dividend  (IB'(g_item_reg.g[k])),
                    .divisor   ({1'b0, sl[k]}),
                    .out_valid (b_v),
                    .out_side  (b_s),
                    .quot      (b_q[k]),
                    .rem       ()
                );

                hscm_div u_div_c (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (pipe_en),
                    .in_valid  (b_v),
                    .in_side   (b_s),
                    .dividend  (nc[k]),
                    .divisor   ({1'b0, cnt[k]}),
                    .out_valid (c_v),
                    .out_side  (c_s),
                    .quot      (),
                    .rem       (c_r[k])
                );
            end
            else
            begin : g_lane
                hscm_div u_div_b (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (pipe_en),
                    .in_valid  (g_v_reg),
                    .in_side   ('0),
                    .dividend  (IB'(g_item_reg.g[k])),
                    .divisor   ({1'b0, sl[k]}),
                    .out_valid (),
                    .out_side  (),
                    .quot      (b_q[k]),
                    .rem       ()
                );

                hscm_div u_div_c (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (pipe_en),
                    .in_valid  (b_v),
                    .in_side   ('0),
                    .dividend  (nc[k]),
                    .divisor   ({1'b0, cnt[k]}),
                    .out_valid (),
                    .out_side  (),
                    .quot      (),
                    .rem       (c_r[k])
                );
            end
        end
    endgenerate

    // rank terms
    hscm_pkg::item_t   m_s_reg;
    logic [CB-1:0]     resid    [ND];
    logic [IB+CB-1:0]  term_full [ND];
    logic [IB-1:0]     term_reg [ND];

    generate
        for (k = 0; k < ND; k++)
        begin : g_term
            // a zero node count adds nothing
            assign resid[k]     = (used[k] && cnt[k] != '0) ? c_r[k][CB-1:0] : '0;
            assign term_full[k] = resid[k] * radix[k];

            always_ff @(posedge clk)
            begin
                if (pipe_en)
                    term_reg[k] <= term_full[k][IB-1:0];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (pipe_en)
            m_v_reg <= c_v;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            m_s_reg <= c_s;
    end

    // output register
    logic [IB-1:0] rank_sum;
    logic          parity_bit;
    logic [CB-1:0] coord_reg [ND];
    logic          halo_reg;
    logic          parity_reg;
    logic [IB-1:0] rank_reg;
    logic          error_reg;

    always_comb
    begin
        rank_sum   = '0;
        parity_bit = 1'b0;
        for (int d = 0; d < ND; d++)
        begin
            rank_sum   = rank_sum + term_reg[d];
            parity_bit = parity_bit ^ m_s_reg.g[d][0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= m_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && m_v_reg)
        begin
            for (int d = 0; d < ND; d++)
                coord_reg[d] <= m_s_reg.err ? '0 : m_s_reg.g[d];
            halo_reg   <= !m_s_reg.err && m_s_reg.halo;
            parity_reg <= !m_s_reg.err && parity_bit;
            rank_reg   <= m_s_reg.err ? '0 : rank_sum;
            error_reg  <= m_s_reg.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phys_coord_0 = coord_reg[0];
    assign phys_coord_1 = coord_reg[1];
    assign phys_coord_2 = coord_reg[2];
    assign phys_coord_3 = coord_reg[3];
    assign is_halo      = halo_reg;
    assign site_parity  = parity_reg;
    assign owner_rank   = rank_reg;
    assign index_error  = error_reg;

endmodule
`default_nettype wire

@@ hdl/hscm_checker.sv @@
// port-level checks of the site coordinate mapper and their bind to the top level
`default_nettype none
module hscm_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  cfg_we,
    input wire logic [hscm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input wire logic [hscm_pkg::REG_BITS-1:0]         cfg_data,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic [hscm_pkg::INDEX_BITS-1:0]       site_index,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic [hscm_pkg::COORD_BITS-1:0]       phys_coord_0,
    input wire logic [hscm_pkg::COORD_BITS-1:0]       phys_coord_1,
    input wire logic [hscm_pkg::COORD_BITS-1:0]       phys_coord_2,
    input wire logic [hscm_pkg::COORD_BITS-1:0]       phys_coord_3,
    input wire logic                                  is_halo,
    input wire logic                                  site_parity,
    input wire logic [hscm_pkg::INDEX_BITS-1:0]       owner_rank,
    input wire logic                                  index_error
);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phys_coord_0) && $stable(phys_coord_1)
            && $stable(phys_coord_2) && $stable(phys_coord_3) && $stable(owner_rank)
            && $stable(is_halo) && $stable(site_parity) && $stable(index_error))
        else $error("stalled result changed");

    // a result only goes away once taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without transaction");

    // an out-of-range index carries nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> phys_coord_0 == '0 && phys_coord_1 == '0
            && phys_coord_2 == '0 && phys_coord_3 == '0 && owner_rank == '0
            && !is_halo && !site_parity)
        else $error("index error with nonzero fields");

    // the input side only stalls behind a full, blocked output
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while output free");

endmodule

bind halo_site_coordinate_mapper_unit hscm_checker u_hscm_checker (.*);
`default_nettype wire
